@@ rtl/tws_pkg.sv @@
`default_nettype none
package tws_pkg;

  // Field and register widths.
  localparam int SIZE_W        = 4;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 4;
  localparam int PHASE_W       = 3;

  // Default geometry and register reset.
  localparam int ADDR_BITS_DEF = 15;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd15;
  localparam logic [4:0] SIZE_MIN = 5'd7;

  // Size thresholds (log2 of bytes) for page size and addressing mode.
  localparam logic [4:0] LOG2_PAGE64 = 5'd14;
  localparam logic [4:0] LOG2_PAGE32 = 5'd12;
  localparam logic [4:0] LOG2_PAGE16 = 5'd9;
  localparam logic [4:0] LOG2_TWO_BYTE = 5'd12;

  localparam logic [5:0] PM_64 = 6'd63;
  localparam logic [5:0] PM_32 = 6'd31;
  localparam logic [5:0] PM_16 = 6'd15;
  localparam logic [5:0] PM_4  = 6'd3;

  // Bus constants.
  localparam logic [3:0] DEV_CODE = 4'ha;
  localparam logic [CNT_W-1:0] ACK_CLOCK = 4'd9;
  localparam logic [BYTE_W-1:0] ERASED = 8'hff;

  // Transfer phases.
  localparam logic [PHASE_W-1:0] PH_STANDBY  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STOP     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_START    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DEVADDR  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_HIGHADDR = 3'd4;
  localparam logic [PHASE_W-1:0] PH_WRITE    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_READ     = 3'd6;

endpackage
`default_nettype wire

@@ rtl/tws_in_if.sv @@
`default_nettype none
// Input channel: one sampled pair of bus lines per word.
interface tws_in_if;
  logic valid;
  logic ready;
  logic sda_in;
  logic scl_in;

  modport source (output valid, output sda_in, output scl_in, input ready);
  modport sink (input valid, input sda_in, input scl_in, output ready);
endinterface
`default_nettype wire

@@ rtl/tws_out_if.sv @@
`default_nettype none
// Result channel: the data line level the device drives, one word per sample.
interface tws_out_if;
  logic valid;
  logic ready;
  logic sda_out;

  modport source (output valid, output sda_out, input ready);
  modport sink (input valid, input sda_out, output ready);
endinterface
`default_nettype wire

@@ rtl/two_wire_eeprom_slave_unit.sv @@
// The result word for a sample is registered into the output queue when the sample is accepted.
// Throughput: one sample per cycle while the skid entry is empty and the memory is not busy;
// a two-entry output queue keeps input flowing while a result waits.
// Reset: control state clears at once, then the memory is swept to 0xFF,
// address by address, while in_chan.ready stays low; configuration writes
// are taken throughout.
`default_nettype none
module two_wire_eeprom_slave_unit #(
  parameter int ADDR_BITS = tws_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [tws_pkg::SIZE_W-1:0]  cfg_wdata,
  tws_in_if.sink                           in_chan,
  tws_out_if.source                        out_chan
);
  import tws_pkg::*;

  localparam logic [4:0] AB5 = 5'(ADDR_BITS);

  // Configuration.
  logic [SIZE_W-1:0] size_r;

  // Protocol state.
  logic                 last_sda_r, last_sda_nxt;
  logic                 last_scl_r, last_scl_nxt;
  logic                 drive_r, drive_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [BYTE_W-1:0]    ctrl_r, ctrl_nxt;
  logic [ADDR_BITS-1:0] wa_r, wa_nxt;
  logic [BYTE_W-1:0]    shifter_r, shifter_nxt;
  logic [CNT_W-1:0]     bitcnt_r, bitcnt_nxt;
  logic                 pend_r, pend_nxt;

  // Output queue: head register and skid entry.
  logic out_v_r, out_m_r, out_b_r;
  logic sk_v_r, sk_m_r, sk_b_r;

  // Memory port.
  logic                 mem_we, mem_re, mem_busy;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [BYTE_W-1:0]    mem_rdata;

  logic                 acc, pop, res_mem;
  logic [4:0]           eff;
  logic                 two_byte;
  logic [ADDR_BITS-1:0] size_mask, pm, wa_next;
  logic [BYTE_W-1:0]    sh_eff;
  logic                 drv_eff;
  logic [CNT_W-1:0]     bc_inc;
  logic [15:0]          dev_tmp;
  logic [ADDR_BITS+BYTE_W-1:0] hi_tmp;
  logic                 fire;

  tws_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (sh_eff),
    .re    (mem_re),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  // Handshakes.
  assign in_chan.ready  = !sk_v_r && !mem_busy;
  assign acc            = in_chan.valid && in_chan.ready;
  assign pop            = out_v_r && out_chan.ready;
  assign out_chan.valid = out_v_r;
  assign out_chan.sda_out = out_m_r ? mem_rdata[BYTE_W-1] : out_b_r;

  // Clamped device size and the geometry it selects.
  always_comb begin
    if ({1'b0, size_r} < SIZE_MIN) begin
      eff = SIZE_MIN;
    end else if ({1'b0, size_r} > AB5) begin
      eff = AB5;
    end else begin
      eff = {1'b0, size_r};
    end
  end

  assign size_mask = ~({ADDR_BITS{1'b1}} << eff);
  assign two_byte  = eff >= LOG2_TWO_BYTE;

  always_comb begin
    if (eff >= LOG2_PAGE64) begin
      pm = ADDR_BITS'(PM_64);
    end else if (eff >= LOG2_PAGE32) begin
      pm = ADDR_BITS'(PM_32);
    end else if (eff >= LOG2_PAGE16) begin
      pm = ADDR_BITS'(PM_16);
    end else begin
      pm = ADDR_BITS'(PM_4);
    end
  end

  // Address increment that wraps inside the current page.
  assign wa_next  = ((wa_r + 1'b1) & pm) | (wa_r & ~pm);
  assign mem_addr = wa_r & size_mask;

  // A read issued on the previous word lands in the shifter lazily.
  assign sh_eff  = pend_r ? {mem_rdata[BYTE_W-2:0], 1'b0} : shifter_r;
  assign drv_eff = pend_r ? mem_rdata[BYTE_W-1] : drive_r;
  assign bc_inc  = bitcnt_r + 1'b1;

  assign dev_tmp = {5'd0, ctrl_r[3:1], sh_eff};
  assign hi_tmp  = {wa_r, sh_eff};

  // Per-sample bus logic.
  always_comb begin
    last_sda_nxt = last_sda_r;
    last_scl_nxt = last_scl_r;
    drive_nxt    = drive_r;
    phase_nxt    = phase_r;
    ctrl_nxt     = ctrl_r;
    wa_nxt       = wa_r;
    shifter_nxt  = shifter_r;
    bitcnt_nxt   = bitcnt_r;
    pend_nxt     = pend_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    res_mem      = 1'b0;
    fire         = 1'b0;
    if (acc) begin
      last_sda_nxt = in_chan.sda_in;
      last_scl_nxt = in_chan.scl_in;
      pend_nxt     = 1'b0;
      shifter_nxt  = sh_eff;
      drive_nxt    = drv_eff;
      if ((in_chan.sda_in != last_sda_r) && in_chan.scl_in) begin
        // Start or stop condition.
        phase_nxt   = in_chan.sda_in ? PH_STOP : PH_START;
        shifter_nxt = '0;
        bitcnt_nxt  = '0;
      end else if (in_chan.scl_in && !last_scl_r) begin
        if (phase_r == PH_READ) begin
          if (bitcnt_r == '0) begin
            // First clock of a read byte: fetch it; its MSB is driven now.
            mem_re     = 1'b1;
            wa_nxt     = wa_next;
            pend_nxt   = 1'b1;
            res_mem    = 1'b1;
            bitcnt_nxt = bc_inc;
          end else begin
            drive_nxt   = sh_eff[BYTE_W-1];
            shifter_nxt = {sh_eff[BYTE_W-2:0], 1'b0};
            if (bc_inc >= ACK_CLOCK) begin
              bitcnt_nxt = '0;
              drive_nxt  = 1'b0;
            end else begin
              bitcnt_nxt = bc_inc;
            end
          end
        end else begin
          if (bc_inc >= ACK_CLOCK) begin
            bitcnt_nxt = '0;
            drive_nxt  = 1'b0;
            fire       = 1'b1;
          end else begin
            bitcnt_nxt  = bc_inc;
            shifter_nxt = {sh_eff[BYTE_W-2:0], in_chan.sda_in};
          end
        end
      end
    end

    // Byte complete on the acknowledge clock.
    if (fire) begin
      case (phase_r)
        PH_STOP: begin
          phase_nxt = PH_STANDBY;
        end
        PH_START: begin
          ctrl_nxt = sh_eff;
          if (sh_eff[7:4] == DEV_CODE) begin
            phase_nxt = sh_eff[0] ? PH_READ : PH_DEVADDR;
          end
        end
        PH_DEVADDR: begin
          if (two_byte) begin
            wa_nxt    = ADDR_BITS'(sh_eff);
            phase_nxt = PH_HIGHADDR;
          end else begin
            wa_nxt    = dev_tmp[ADDR_BITS-1:0];
            phase_nxt = PH_WRITE;
          end
        end
        PH_HIGHADDR: begin
          wa_nxt    = hi_tmp[ADDR_BITS-1:0];
          phase_nxt = PH_WRITE;
        end
        PH_WRITE: begin
          mem_we = 1'b1;
          wa_nxt = wa_next;
        end
        PH_STANDBY, PH_READ: begin
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Protocol state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sda_r <= 1'b1;
      last_scl_r <= 1'b1;
      drive_r    <= 1'b1;
      phase_r    <= PH_STANDBY;
      ctrl_r     <= '0;
      wa_r       <= '0;
      shifter_r  <= '0;
      bitcnt_r   <= '0;
      pend_r     <= 1'b0;
    end else begin
      last_sda_r <= last_sda_nxt;
      last_scl_r <= last_scl_nxt;
      drive_r    <= drive_nxt;
      phase_r    <= phase_nxt;
      ctrl_r     <= ctrl_nxt;
      wa_r       <= wa_nxt;
      shifter_r  <= shifter_nxt;
      bitcnt_r   <= bitcnt_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // Output queue: the head feeds the port, the skid entry catches one more word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      out_m_r <= 1'b0;
      sk_v_r  <= 1'b0;
      sk_m_r  <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        out_m_r <= sk_m_r;
        out_b_r <= sk_b_r;
        sk_v_r  <= acc;
        sk_m_r  <= res_mem;
        sk_b_r  <= drive_nxt;
      end else begin
        out_v_r <= acc;
        out_m_r <= res_mem;
        out_b_r <= drive_nxt;
        sk_v_r  <= 1'b0;
      end
    end else if (acc) begin
      sk_v_r <= 1'b1;
      sk_m_r <= res_mem;
      sk_b_r <= drive_nxt;
    end
  end

  // The skid entry is only ever filled behind a waiting head.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid entry valid without head entry");

  // A pending fetch belongs to the first clock of a read byte.
  a_pend_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (phase_r == PH_READ && bitcnt_r == 4'd1))
    else $error("pending read data outside a read byte");

  // Read data feeding a waiting result must not be overwritten.
  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_m_r) |-> !mem_re)
    else $error("new read while a result still uses read data");

  // The bit counter never rests at the acknowledge clock.
  a_bitcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bitcnt_r < ACK_CLOCK)
    else $error("bit counter out of range");

endmodule
`default_nettype wire

@@ rtl/tws_mem.sv @@
`default_nettype none
module tws_mem #(
  parameter int ADDR_BITS = tws_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        we,
  input  wire logic [ADDR_BITS-1:0]        addr,
  input  wire logic [tws_pkg::BYTE_W-1:0]  wdata,
  input  wire logic                        re,
  output logic      [tws_pkg::BYTE_W-1:0]  rdata,
  output logic                             busy
);
  import tws_pkg::*;

  logic [BYTE_W-1:0]    mem [2**ADDR_BITS];
  logic [BYTE_W-1:0]    rdata_r;
  logic [ADDR_BITS-1:0] clr_addr_r;
  logic                 busy_r;

  // Erase sweep after reset: one byte per cycle to the erased value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Single write port, shared by the sweep and the byte writes.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= ERASED;
    end else if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule
`default_nettype wire

@@ tb/tws_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels, predicts the data line level that the device drives
// for every accepted pin sample, and compares it with each returned word.
module tws_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [tws_pkg::SIZE_W-1:0] cfg_wdata,
  tws_in_if                               in_chan,
  tws_out_if                              out_chan,
  output int                              mismatch_count,
  output int                              levels_due
);
  import tws_pkg::*;

  localparam int AW = ADDR_BITS_DEF;
  localparam int MEM_DEPTH = 1 << AW;

  // Local copy of the device state.
  logic [BYTE_W-1:0]  mem_image [MEM_DEPTH];
  logic [SIZE_W-1:0]  size_reg;
  logic               prev_sda;
  logic               prev_scl;
  logic               drive_level;
  logic [PHASE_W-1:0] bus_phase;
  logic [BYTE_W-1:0]  ctrl_byte;
  logic [BYTE_W-1:0]  shift_reg;
  logic [AW-1:0]      word_addr;
  logic [CNT_W-1:0]   bit_cnt;

  // Levels predicted for accepted samples, oldest first.
  logic               drive_queue [$];
  logic               want_level;

  // The size register is clamped to the range the device supports.
  function automatic int size_log2_eff();
    if (size_reg < SIZE_MIN) return int'(SIZE_MIN);
    if (size_reg > AW) return AW;
    return int'(size_reg);
  endfunction

  function automatic logic [AW-1:0] page_mask();
    int lg;
    lg = size_log2_eff();
    if (lg >= LOG2_PAGE64) return AW'(PM_64);
    if (lg >= LOG2_PAGE32) return AW'(PM_32);
    if (lg >= LOG2_PAGE16) return AW'(PM_16);
    return AW'(PM_4);
  endfunction

  // Memory accesses see the word address folded into the configured size.
  function automatic logic [AW-1:0] mem_index();
    logic [AW:0] span;
    span = (AW+1)'(1);
    span = span << size_log2_eff();
    span = span - 1'b1;
    return word_addr & span[AW-1:0];
  endfunction

  // The address increments within its page and wraps at the page end.
  task automatic step_address();
    logic [AW-1:0] pm;
    pm = page_mask();
    word_addr = ((word_addr + 1'b1) & pm) | (word_addr & ~pm);
  endtask

  // Applies one sample of the bus lines to the local state.
  task automatic sample_bus_lines(input logic sda, input logic scl);
    if (sda != prev_sda && scl) begin
      // A data change while the clock is high is a start or a stop.
      bus_phase = sda ? PH_STOP : PH_START;
      shift_reg = '0;
      bit_cnt = '0;
    end else if (scl != prev_scl && scl) begin
      if (bus_phase == PH_READ) begin
        if (bit_cnt == '0) begin
          shift_reg = mem_image[mem_index()];
          step_address();
        end
        drive_level = shift_reg[BYTE_W-1];
        shift_reg = shift_reg << 1;
        bit_cnt++;
        if (bit_cnt >= ACK_CLOCK) begin
          bit_cnt = '0;
          drive_level = 1'b0;
        end
      end else begin
        bit_cnt++;
        if (bit_cnt < ACK_CLOCK) shift_reg = {shift_reg[BYTE_W-2:0], sda};
      end
      // Ninth clock: acknowledge and act on the byte just shifted in.
      if (bit_cnt >= ACK_CLOCK) begin
        bit_cnt = '0;
        drive_level = 1'b0;
        case (bus_phase)
          PH_STOP: begin
            bus_phase = PH_STANDBY;
          end
          PH_START: begin
            ctrl_byte = shift_reg;
            if (ctrl_byte[7:4] == DEV_CODE) begin
              bus_phase = ctrl_byte[0] ? PH_READ : PH_DEVADDR;
            end
          end
          PH_DEVADDR: begin
            word_addr = '0;
            word_addr[7:0] = shift_reg;
            if (size_log2_eff() >= LOG2_TWO_BYTE) begin
              bus_phase = PH_HIGHADDR;
            end else begin
              // Small devices take the top address bits from the device byte.
              word_addr[10:8] = ctrl_byte[3:1];
              bus_phase = PH_WRITE;
            end
          end
          PH_HIGHADDR: begin
            word_addr = {word_addr[AW-9:0], shift_reg};
            bus_phase = PH_WRITE;
          end
          PH_WRITE: begin
            mem_image[mem_index()] = shift_reg;
            step_address();
          end
          PH_STANDBY, PH_READ: begin
          end
          default: begin
            bus_phase = PH_STOP;
          end
        endcase
      end
    end
    prev_sda = sda;
    prev_scl = scl;
  endtask

  task automatic report_mismatch(input logic want, input logic got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("sda_out mismatch at %0t ns: expected %b, actual %b", $time, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEM_DEPTH; i++) mem_image[i] = ERASED;
      size_reg = SIZE_RESET;
      prev_sda = 1'b1;
      prev_scl = 1'b1;
      drive_level = 1'b1;
      bus_phase = PH_STANDBY;
      ctrl_byte = '0;
      shift_reg = '0;
      word_addr = '0;
      bit_cnt = '0;
      drive_queue.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      // Returned words are matched first, so a word can never meet its own sample.
      if (out_chan.valid && out_chan.ready) begin
        if (drive_queue.size() == 0) begin
          report_mismatch(1'bx, out_chan.sda_out);
        end else begin
          want_level = drive_queue.pop_front();
          if (want_level !== out_chan.sda_out) report_mismatch(want_level, out_chan.sda_out);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        sample_bus_lines(in_chan.sda_in, in_chan.scl_in);
        drive_queue.push_back(drive_level);
      end
    end
    levels_due <= drive_queue.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Drives two-wire bus traffic into the EEPROM slave one pin sample per word
// and reports the verdict from the checker.
module tb;
  import tws_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int                mismatch_count;
  int                levels_due;

  tws_in_if  in_bus ();
  tws_out_if out_bus ();

  // Stimulus state.
  logic cur_sda = 1'b1;
  logic cur_scl = 1'b1;
  int   samples_sent = 0;
  int   in_gap_odds = 0;
  int   out_stall_odds = 0;
  bit   two_byte = 1'b1;

  two_wire_eeprom_slave_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  tws_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_chan       (in_bus),
    .out_chan      (out_bus),
    .mismatch_count(mismatch_count),
    .levels_due    (levels_due)
  );

  always #10 clk = ~clk;

  // Hard stop in case the handshake hangs.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stall bursts while out_stall_odds is nonzero.
  initial begin
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Sends one pin sample as a word, with an optional idle burst before it.
  task automatic send_pins(input logic sda, input logic scl);
    if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.sda_in <= sda;
    in_bus.scl_in <= scl;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    cur_sda = sda;
    cur_scl = scl;
    samples_sent++;
  endtask

  // One clock period with the data line held; each level lasts one or two samples.
  task automatic clock_bit(input logic level);
    repeat (($urandom_range(0, 3) == 0) ? 2 : 1) send_pins(level, 1'b0);
    repeat (($urandom_range(0, 3) == 0) ? 2 : 1) send_pins(level, 1'b1);
  endtask

  task automatic send_byte(input logic [7:0] data, input logic ack_level);
    for (int i = 7; i >= 0; i--) clock_bit(data[i]);
    clock_bit(ack_level);
  endtask

  task automatic bus_start();
    if (cur_scl) send_pins(cur_sda, 1'b0);
    send_pins(1'b1, 1'b0);
    send_pins(1'b1, 1'b1);
    send_pins(1'b0, 1'b1);
  endtask

  task automatic bus_stop();
    if (cur_scl) send_pins(cur_sda, 1'b0);
    send_pins(1'b0, 1'b0);
    send_pins(1'b0, 1'b1);
    send_pins(1'b1, 1'b1);
  endtask

  task automatic send_address(input logic [15:0] addr);
    bus_start();
    send_byte({DEV_CODE, addr[10:8], 1'b0}, 1'b1);
    if (two_byte) send_byte(addr[15:8], 1'b1);
    send_byte(addr[7:0], 1'b1);
  endtask

  // Byte write or page write of random data.
  task automatic eeprom_write(input logic [15:0] addr, input int count);
    send_address(addr);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b1);
    bus_stop();
  endtask

  // Random read when set_addr is high, current-address read otherwise.
  task automatic eeprom_read(input bit set_addr, input logic [15:0] addr, input int count);
    if (set_addr) send_address(addr);
    bus_start();
    send_byte({DEV_CODE, addr[10:8], 1'b1}, 1'b1);
    for (int i = 0; i < count; i++) send_byte(8'($urandom_range(0, 255)), i == count - 1);
    bus_stop();
  endtask

  // Transfers cut short or addressed to another device.
  task automatic broken_transfer();
    int         kind;
    logic [3:0] code;
    kind = $urandom_range(0, 2);
    code = 4'($urandom_range(0, 15));
    if (code == DEV_CODE) code = ~DEV_CODE;
    bus_start();
    case (kind)
      0: begin
        send_byte({code, 4'($urandom_range(0, 15))}, 1'b1);
        repeat ($urandom_range(0, 12)) clock_bit(1'($urandom_range(0, 1)));
      end
      1: begin
        repeat ($urandom_range(1, 8)) clock_bit(1'($urandom_range(0, 1)));
      end
      default: begin
        send_byte({DEV_CODE, 3'($urandom_range(0, 7)), 1'b0}, 1'b1);
        repeat ($urandom_range(1, 7)) clock_bit(1'($urandom_range(0, 1)));
        bus_start();
        repeat ($urandom_range(1, 7)) clock_bit(1'($urandom_range(0, 1)));
      end
    endcase
    bus_stop();
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (levels_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // One configuration setting followed by random transfers.
  task automatic run_phase(input logic [SIZE_W-1:0] size_val, input int budget,
                           input int gap_odds, input int stall_odds);
    int          stop_at;
    int          pick;
    int          count;
    logic [15:0] addr;
    write_size(size_val);
    two_byte = (size_val >= LOG2_TWO_BYTE);
    in_gap_odds = gap_odds;
    out_stall_odds = stall_odds;
    stop_at = samples_sent + budget;
    while (samples_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      // Half the addresses fall in a low window so reads find written data.
      addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'hffff))
                                  : 16'($urandom_range(0, 127));
      count = $urandom_range(1, 8);
      if (pick < 35) begin
        eeprom_write(addr, count);
      end else if (pick < 55) begin
        eeprom_read(1'b1, addr, count);
      end else if (pick < 68) begin
        eeprom_read(1'b0, addr, count);
      end else if (pick < 78) begin
        repeat ($urandom_range(4, 16)) begin
          send_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else if (pick < 92) begin
        broken_transfer();
      end else begin
        // Clocks outside any transfer still count bits up to an acknowledge.
        repeat ($urandom_range(9, 20)) clock_bit(1'($urandom_range(0, 1)));
      end
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.sda_in <= 1'b1;
    in_bus.scl_in <= 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Clocks in standby still count out a byte and draw an acknowledge.
    for (int i = 0; i < 9; i++) begin
      send_pins(1'b1, 1'b0);
      send_pins(1'b1, 1'b1);
    end
    // Stop, then data and clock changing together (a start), then a stop.
    send_pins(1'b0, 1'b0);
    send_pins(1'b0, 1'b1);
    send_pins(1'b1, 1'b1);
    send_pins(1'b1, 1'b0);
    send_pins(1'b0, 1'b1);
    send_pins(1'b1, 1'b1);
    drain();

    // Each phase overshoots its budget by the tail of its last transfer.
    run_phase(4'd15, 125, 6, 6);
    run_phase(4'd0, 135, 0, 4);
    run_phase(4'd7, 135, 4, 0);
    run_phase(4'd11, 135, 10, 10);
    run_phase(4'd12, 135, 3, 3);
    run_phase(4'd9, 135, 20, 5);
    run_phase(4'd14, 135, 5, 20);
    run_phase(4'd13, 135, 8, 8);
    // Final stretch runs without idling on either side.
    run_phase(4'd15, 135, 0, 0);

    if (mismatch_count == 0 && levels_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tws_pkg.sv
rtl/tws_in_if.sv
rtl/tws_out_if.sv
rtl/tws_mem.sv
rtl/two_wire_eeprom_slave_unit.sv
tb/tws_checker.sv
tb/tb.sv
